FILE: rtl/tccw_pkg.sv
// shared types and constants of the text console character writer
`default_nettype none

package tccw_pkg;

  localparam int COLS_DEFAULT = 80;
  localparam int ROWS_DEFAULT = 25;

  localparam int CHAR_W   = 8;
  localparam int ATTR_W   = 8;
  localparam int CELL_W   = 16;
  localparam int IN_ROW_W = 5;
  localparam int IN_COL_W = 7;
  localparam int OUT_OFS_W = 11;

  localparam int QUEUE_DEPTH = 4;
  localparam int TAB_STOP    = 8;

  localparam logic [CHAR_W-1:0] CHAR_TAB    = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_CR     = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_LF     = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_PROMPT = 8'h3E;
  localparam logic [CHAR_W-1:0] CHAR_BLANK  = 8'h20;

  localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h0F;
  localparam logic              RESET_PROMPT = 1'b1;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_ATTR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROMPT_EN = 2'd1;

  typedef enum logic [2:0] {
    OP_READ      = 3'd0,
    OP_READ_MISS = 3'd1,
    OP_TAB       = 3'd2,
    OP_CR        = 3'd3,
    OP_LF        = 3'd4,
    OP_GLYPH     = 3'd5
  } op_kind_e;

  typedef struct packed {
    op_kind_e              kind;
    logic [CHAR_W-1:0]     char_code;
    logic [IN_ROW_W-1:0]   row;
    logic [IN_COL_W-1:0]   col;
  } op_t;

  typedef struct packed {
    logic [ATTR_W-1:0] attr;
    logic              prompt_en;
  } cfg_t;

  typedef struct packed {
    logic                 scrolled;
    logic [OUT_OFS_W-1:0] offset;
    logic [IN_COL_W-1:0]  col;
    logic [IN_ROW_W-1:0]  row;
    logic [CELL_W-1:0]    value;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/tccw_front.sv
// input stage: accepts stream transactions and classifies them into operations
`default_nettype none

module tccw_front
  import tccw_pkg::*;
#(
  parameter int COLS = COLS_DEFAULT,
  parameter int ROWS = ROWS_DEFAULT
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                en_i,
  input  wire logic                in_valid_i,
  output      logic                in_ready_o,
  input  wire logic                func_i,
  input  wire logic [CHAR_W-1:0]   char_code_i,
  input  wire logic [IN_ROW_W-1:0] cell_row_i,
  input  wire logic [IN_COL_W-1:0] cell_col_i,
  output      logic                op_valid_o,
  input  wire logic                op_ready_i,
  output      op_t                 op_o
);

  logic valid_q, valid_d;
  op_t  op_q, op_d;
  logic accept;
  logic in_range;

  assign in_ready_o = en_i && (!valid_q || op_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign in_range   = (32'(cell_row_i) < ROWS) && (32'(cell_col_i) < COLS);

  always_comb begin
    op_d           = op_q;
    op_d.char_code = char_code_i;
    op_d.row       = cell_row_i;
    op_d.col       = cell_col_i;
    if (func_i) begin
      op_d.kind = in_range ? OP_READ : OP_READ_MISS;
    end else begin
      priority if (char_code_i == CHAR_TAB) begin
        op_d.kind = OP_TAB;
      end else if (char_code_i == CHAR_CR) begin
        op_d.kind = OP_CR;
      end else if (char_code_i == CHAR_LF) begin
        op_d.kind = OP_LF;
      end else begin
        op_d.kind = OP_GLYPH;
      end
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (op_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= op_d;
    end
  end

  assign op_valid_o = valid_q;
  assign op_o       = op_q;

endmodule

`default_nettype wire

FILE: rtl/tccw_queue.sv
// small fifo of classified operations between the front and back parts
`default_nettype none

module tccw_queue
  import tccw_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_valid_i,
  output      logic push_ready_o,
  input  wire op_t  push_data_i,
  output      logic pop_valid_o,
  input  wire logic pop_ready_i,
  output      op_t  pop_data_o
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  op_t           entries [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [NW-1:0] count_q, count_d;
  logic          push, pop;

  assign push_ready_o = (count_q != NW'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = entries[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? PW'(wr_ptr_q + 1'b1) : wr_ptr_q;
    rd_ptr_d = pop ? PW'(rd_ptr_q + 1'b1) : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = NW'(count_q + 1'b1);
    end else if (pop && !push) begin
      count_d = NW'(count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tccw_back.sv
// execution engine: screen memory, cursor, scroll and clear sequencer, result register
`default_nettype none

module tccw_back
  import tccw_pkg::*;
#(
  parameter int COLS = COLS_DEFAULT,
  parameter int ROWS = ROWS_DEFAULT
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire cfg_t    cfg_i,
  input  wire logic    op_valid_i,
  output      logic    op_ready_o,
  input  wire op_t     op_i,
  output      logic    res_valid_o,
  input  wire logic    res_ready_i,
  output      result_t res_o,
  output      logic    clearing_o
);

  localparam int CELLS = ROWS * COLS;
  localparam int MOVES = CELLS - COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLS);

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_EXEC  = 7'b0000100,
    ST_GLYPH = 7'b0001000,
    ST_COPY  = 7'b0010000,
    ST_BLANK = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_e;

  state_e            state_q, state_d;
  op_t               op_q, op_d;
  logic [RW-1:0]     row_q, row_d;
  logic [CW-1:0]     col_q, col_d;
  logic [AW-1:0]     cnt_q, cnt_d;
  logic [1:0]        pend_q, pend_d;
  logic [CHAR_W-1:0] glyph_q, glyph_d;
  logic              scroll_q, scroll_d;
  logic              hit_q, hit_d;
  logic              out_valid_q, out_valid_d;
  result_t           out_q, out_d;

  logic [CELL_W-1:0] mem [CELLS];
  logic [CELL_W-1:0] rdata_q;
  logic              we, re;
  logic [AW-1:0]     waddr, raddr;
  logic [CELL_W-1:0] wdata;

  logic [AW-1:0]     cur_addr, rd_addr;
  logic [CW:0]       col_inc, tab_col;
  logic              last_row;
  logic              do_scroll;

  localparam logic [CW:0] WRAP_COL = (CW+1)'(COLS - 1);

  assign cur_addr = AW'(AW'(row_q) * AW'(COLS)) + AW'(col_q);
  assign rd_addr  = AW'(AW'(op_q.row) * AW'(COLS)) + AW'(op_q.col);
  assign col_inc  = {1'b0, col_q} + 1'b1;
  assign tab_col  = ({1'b0, col_q} + (CW+1)'(TAB_STOP)) & ~((CW+1)'(TAB_STOP - 1));
  assign last_row = (row_q == RW'(ROWS - 1));

  assign op_ready_o  = (state_q == ST_IDLE) && (!out_valid_q || res_ready_i);
  assign clearing_o  = (state_q == ST_CLEAR);
  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    row_d       = row_q;
    col_d       = col_q;
    cnt_d       = cnt_q;
    pend_d      = pend_q;
    glyph_d     = glyph_q;
    scroll_d    = scroll_q;
    hit_d       = hit_q;
    out_valid_d = out_valid_q && !res_ready_i;
    out_d       = out_q;
    we          = 1'b0;
    re          = 1'b0;
    waddr       = cur_addr;
    raddr       = rd_addr;
    wdata       = {cfg_i.attr, glyph_q};
    do_scroll   = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = cnt_q;
        wdata = {RESET_ATTR, CHAR_BLANK};
        if (cnt_q == AW'(CELLS - 1)) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end else begin
          cnt_d = AW'(cnt_q + 1'b1);
        end
      end
      ST_IDLE: begin
        if (op_valid_i && op_ready_o) begin
          op_d     = op_i;
          scroll_d = 1'b0;
          hit_d    = 1'b0;
          state_d  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (op_q.kind)
          OP_READ: begin
            re      = 1'b1;
            hit_d   = 1'b1;
            state_d = ST_DONE;
          end
          OP_READ_MISS: begin
            state_d = ST_DONE;
          end
          OP_CR: begin
            col_d   = '0;
            state_d = ST_DONE;
          end
          OP_TAB: begin
            state_d = ST_DONE;
            if (tab_col >= WRAP_COL) begin
              col_d = '0;
              if (last_row) begin
                do_scroll = 1'b1;
              end else begin
                row_d = RW'(row_q + 1'b1);
              end
            end else begin
              col_d = tab_col[CW-1:0];
            end
          end
          OP_LF: begin
            col_d   = '0;
            glyph_d = CHAR_PROMPT;
            pend_d  = cfg_i.prompt_en ? 2'd2 : 2'd0;
            state_d = cfg_i.prompt_en ? ST_GLYPH : ST_DONE;
            if (last_row) begin
              do_scroll = 1'b1;
            end else begin
              row_d = RW'(row_q + 1'b1);
            end
          end
          OP_GLYPH: begin
            glyph_d = op_q.char_code;
            pend_d  = 2'd1;
            state_d = ST_GLYPH;
          end
          default: begin
            state_d = ST_DONE;
          end
        endcase
      end
      ST_GLYPH: begin
        we      = 1'b1;
        pend_d  = pend_q - 1'b1;
        state_d = (pend_q == 2'd1) ? ST_DONE : ST_GLYPH;
        if (col_inc >= WRAP_COL) begin
          col_d = '0;
          if (last_row) begin
            do_scroll = 1'b1;
          end else begin
            row_d = RW'(row_q + 1'b1);
          end
        end else begin
          col_d = col_inc[CW-1:0];
        end
      end
      ST_COPY: begin
        if (cnt_q != AW'(MOVES)) begin
          re    = 1'b1;
          raddr = AW'(cnt_q + AW'(COLS));
          cnt_d = AW'(cnt_q + 1'b1);
        end else begin
          state_d = ST_BLANK;
        end
        if (cnt_q != '0) begin
          we    = 1'b1;
          waddr = AW'(cnt_q - 1'b1);
          wdata = rdata_q;
        end
      end
      ST_BLANK: begin
        we    = 1'b1;
        waddr = cnt_q;
        wdata = {cfg_i.attr, CHAR_BLANK};
        if (cnt_q == AW'(CELLS - 1)) begin
          state_d = (pend_q != 2'd0) ? ST_GLYPH : ST_DONE;
        end else begin
          cnt_d = AW'(cnt_q + 1'b1);
        end
      end
      ST_DONE: begin
        out_valid_d    = 1'b1;
        out_d.value    = hit_q ? rdata_q : '0;
        out_d.row      = IN_ROW_W'(row_q);
        out_d.col      = IN_COL_W'(col_q);
        out_d.offset   = OUT_OFS_W'(cur_addr);
        out_d.scrolled = scroll_q;
        state_d        = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (do_scroll) begin
      row_d    = RW'(ROWS - 1);
      col_d    = '0;
      cnt_d    = '0;
      scroll_d = 1'b1;
      state_d  = ST_COPY;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      row_q       <= '0;
      col_q       <= '0;
      cnt_q       <= '0;
      pend_q      <= '0;
      scroll_q    <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_q       <= row_d;
      col_q       <= col_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      scroll_q    <= scroll_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    glyph_q <= glyph_d;
    out_q   <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/text_console_char_writer.sv
// top level of the text console character writer
`default_nettype none

// Text console engine over a ROWS x COLS screen of 16-bit cells (attribute in the high
// byte, character in the low byte), one result per input transaction. After reset the
// screen is swept to blank cells with attribute 0x0F, one cell per cycle, so the input
// side holds tready low until the sweep is done; configuration writes are taken at any
// time. A front stage classifies each transaction and hands it through a four-entry
// queue to the engine, which owns the screen memory and its one read and one write port.
// The engine takes a new transaction only once it is through with the last one and its
// result register is free; the front stage and the queue go on taking transactions
// until the queue is full. A scroll moves the screen up one row, one cell move per cycle
// through the memory ports, then one blank write per cell of the bottom row.
module text_console_char_writer
  import tccw_pkg::*;
#(
  parameter int COLS = COLS_DEFAULT,
  parameter int ROWS = ROWS_DEFAULT
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // input stream
  input  wire logic                 s_axis_tvalid,
  output      logic                 s_axis_tready,
  // tdata: char_code [7:0], cell_row [12:8], cell_col [19:13], zero [23:20]
  input  wire logic [23:0]          s_axis_tdata,
  // tuser: func [0]
  input  wire logic [0:0]           s_axis_tuser,
  // result stream
  output      logic                 m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // tdata: cell_value [15:0], cursor_row [20:16], cursor_col [27:21],
  //        cursor_pos [38:28], scrolled [39]
  output      logic [39:0]          m_axis_tdata,
  // configuration writes
  input  wire logic                 cfg_valid_i,
  output      logic                 cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [7:0]           cfg_data_i
);

  cfg_t    cfg_q, cfg_d;
  logic    clearing;
  logic    front_valid, front_ready;
  op_t     front_op;
  logic    queue_valid, queue_ready;
  op_t     queue_op;
  result_t res;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_TEXT_ATTR: cfg_d.attr      = cfg_data_i;
        REG_PROMPT_EN: cfg_d.prompt_en = cfg_data_i[0];
        default:       cfg_d           = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.attr      <= RESET_ATTR;
      cfg_q.prompt_en <= RESET_PROMPT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  tccw_front #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (!clearing),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .func_i     (s_axis_tuser[0]),
    .char_code_i(s_axis_tdata[7:0]),
    .cell_row_i (s_axis_tdata[12:8]),
    .cell_col_i (s_axis_tdata[19:13]),
    .op_valid_o (front_valid),
    .op_ready_i (front_ready),
    .op_o       (front_op)
  );

  tccw_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(front_valid),
    .push_ready_o(front_ready),
    .push_data_i (front_op),
    .pop_valid_o (queue_valid),
    .pop_ready_i (queue_ready),
    .pop_data_o  (queue_op)
  );

  tccw_back #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .op_valid_i (queue_valid),
    .op_ready_o (queue_ready),
    .op_i       (queue_op),
    .res_valid_o(m_axis_tvalid),
    .res_ready_i(m_axis_tready),
    .res_o      (res),
    .clearing_o (clearing)
  );

  assign m_axis_tdata = res;

endmodule

`default_nettype wire

FILE: rtl/tccw_checker.sv
// port-level assertions of the text console character writer and their bind
`default_nettype none

module tccw_checker
  import tccw_pkg::*;
#(
  parameter int COLS = COLS_DEFAULT,
  parameter int ROWS = ROWS_DEFAULT
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [39:0] m_axis_tdata
);

  // a stalled result holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // the cursor never rests on the last column
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[27:21] < 7'(COLS - 1)))
    else $error("cursor column on last column");

  // a scroll leaves the cursor on the bottom row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[39] |-> (m_axis_tdata[20:16] == 5'(ROWS - 1)))
    else $error("scrolled result not on bottom row");

  // the screen clear keeps input closed right after reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !s_axis_tready)
    else $error("input open during screen clear");

endmodule

bind text_console_char_writer tccw_checker #(
  .COLS(COLS),
  .ROWS(ROWS)
) u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

`default_nettype wire

FILE: sim/text_console_char_writer_tb.sv
// testbench for the text console character writer: random and directed puts and reads
`timescale 1ns / 1ps

module text_console_char_writer_tb;
  import tccw_pkg::*;

  localparam int NUM_COLS = COLS_DEFAULT;
  localparam int NUM_ROWS = ROWS_DEFAULT;
  localparam int NUM_CELLS = NUM_COLS * NUM_ROWS;
  localparam logic FUNC_PUT = 1'b0;
  localparam logic FUNC_READ = 1'b1;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_AT = 300;
  localparam int HOLD_CYCLES = 600;
  localparam int SETTLE_CYCLES = 20;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic                func;
    logic [CHAR_W-1:0]   code;
    logic [IN_ROW_W-1:0] row;
    logic [IN_COL_W-1:0] col;
  } console_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic [0:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [7:0] cfg_data_i = '0;

  text_console_char_writer uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // screen and cursor as the block should hold them
  logic [CELL_W-1:0] screen_model [NUM_CELLS];
  int unsigned cur_row, cur_col;
  logic [ATTR_W-1:0] attr_model;
  logic prompt_model;
  bit scroll_seen;

  console_item_t console_items_q [$];
  result_t expected_results_q [$];
  console_item_t held_item;

  bit send_idle, recv_idle;
  int unsigned send_gap, recv_stall, hold_left;
  int unsigned n_errors, n_reports, n_results, n_puts, n_reads, n_off_screen;
  int unsigned n_scrolls, n_cfg, n_items, quiet_cycles;

  function automatic void shift_screen_up();
    int i;
    for (i = 0; i < NUM_CELLS - NUM_COLS; i++) screen_model[i] = screen_model[i + NUM_COLS];
    for (i = NUM_CELLS - NUM_COLS; i < NUM_CELLS; i++) screen_model[i] = {attr_model, CHAR_BLANK};
    cur_row = NUM_ROWS - 1;
    cur_col = 0;
    scroll_seen = 1'b1;
  endfunction

  function automatic void settle_cursor();
    if (cur_col >= NUM_COLS - 1) begin
      cur_row++;
      cur_col = 0;
    end
    if (cur_row >= NUM_ROWS) shift_screen_up();
  endfunction

  function automatic void put_glyph(input logic [CHAR_W-1:0] code);
    screen_model[cur_row * NUM_COLS + cur_col] = {attr_model, code};
    cur_col++;
    settle_cursor();
  endfunction

  function automatic void put_char(input logic [CHAR_W-1:0] code);
    if (code == CHAR_TAB) begin
      cur_col = (cur_col + TAB_STOP) / TAB_STOP * TAB_STOP;
      settle_cursor();
    end else if (code == CHAR_CR) begin
      cur_col = 0;
      settle_cursor();
    end else if (code == CHAR_LF) begin
      if (cur_row >= NUM_ROWS - 1) shift_screen_up();
      else cur_row++;
      cur_col = 0;
      if (prompt_model) begin
        put_glyph(CHAR_PROMPT);
        put_glyph(CHAR_PROMPT);
      end
      settle_cursor();
    end else begin
      put_glyph(code);
    end
  endfunction

  function automatic result_t predict_console(input console_item_t it);
    result_t r;
    r = '0;
    scroll_seen = 1'b0;
    if (it.func == FUNC_PUT) begin
      put_char(it.code);
      n_puts++;
    end else begin
      n_reads++;
      if (it.row < NUM_ROWS && it.col < NUM_COLS) r.value = screen_model[it.row * NUM_COLS + it.col];
      else n_off_screen++;
    end
    r.row = IN_ROW_W'(cur_row);
    r.col = IN_COL_W'(cur_col);
    r.offset = OUT_OFS_W'(cur_row * NUM_COLS + cur_col);
    r.scrolled = scroll_seen;
    if (scroll_seen) n_scrolls++;
    return r;
  endfunction

  // input driver
  always @(posedge clk_i) begin : input_driver
    bit fired;
    fired = 1'b0;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results_q.push_back(predict_console(held_item));
        n_items++;
        fired = 1'b1;
        send_gap = send_idle ? $urandom_range(0, 9) : 0;
      end
      if (!s_axis_tvalid || fired) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (console_items_q.size() > 0) begin
          held_item = console_items_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {4'b0, held_item.col, held_item.row, held_item.code};
          s_axis_tuser <= held_item.func;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk_i) begin : result_monitor
    result_t got, want;
    bit fired;
    fired = 1'b0;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'(m_axis_tdata);
        fired = 1'b1;
        n_results++;
        if (expected_results_q.size() == 0) begin
          n_errors++;
          if (n_reports < MAX_REPORTS) begin
            n_reports++;
            $display("unexpected result transaction %h", m_axis_tdata);
          end
        end else begin
          want = expected_results_q.pop_front();
          if (got.value !== want.value || got.row !== want.row || got.col !== want.col ||
              got.offset !== want.offset || got.scrolled !== want.scrolled) begin
            n_errors++;
            if (n_reports < MAX_REPORTS) begin
              n_reports++;
              $display("result %0d mismatch: value %h/%h row %0d/%0d col %0d/%0d",
                       n_results, want.value, got.value, want.row, got.row, want.col, got.col);
              $display("  offset %0d/%0d scrolled %0b/%0b (expected/actual)",
                       want.offset, got.offset, want.scrolled, got.scrolled);
            end
          end
        end
        recv_stall = recv_idle ? $urandom_range(0, 9) : 0;
        if (n_results == HOLD_AT) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                 quiet_cycles, expected_results_q.size());
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic push_put(input logic [CHAR_W-1:0] code);
    console_item_t it;
    it.func = FUNC_PUT;
    it.code = code;
    it.row = IN_ROW_W'($urandom);
    it.col = IN_COL_W'($urandom);
    console_items_q.push_back(it);
  endtask

  task automatic push_read(input logic [IN_ROW_W-1:0] row, input logic [IN_COL_W-1:0] col);
    console_item_t it;
    it.func = FUNC_READ;
    it.code = CHAR_W'($urandom);
    it.row = row;
    it.col = col;
    console_items_q.push_back(it);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == REG_TEXT_ATTR) attr_model = data;
    else if (idx == REG_PROMPT_EN) prompt_model = data[0];
    n_cfg++;
  endtask

  // text lines, blank lines, read bursts and noise
  task automatic add_random_items(input int unsigned count);
    int unsigned added, kind, len, k;
    added = 0;
    while (added < count) begin
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 100) : $urandom_range(0, 15);
        for (k = 0; k < len; k++) push_put(CHAR_W'($urandom_range(8'h20, 8'h7E)));
        added += len + 1;
        case ($urandom_range(0, 9))
          0, 1: push_put(CHAR_CR);
          2: push_put(CHAR_TAB);
          default: push_put(CHAR_LF);
        endcase
      end else if (kind == 5) begin
        len = $urandom_range(2, 8);
        repeat (len) push_put(CHAR_LF);
        added += len;
      end else if (kind < 8) begin
        len = $urandom_range(1, 4);
        for (k = 0; k < len; k++) begin
          if ($urandom_range(0, 3) == 0) push_read(IN_ROW_W'($urandom), IN_COL_W'($urandom));
          else push_read(IN_ROW_W'($urandom_range(0, NUM_ROWS - 1)),
                         IN_COL_W'($urandom_range(0, NUM_COLS - 1)));
        end
        added += len;
      end else begin
        case ($urandom_range(0, 3))
          0: push_put(CHAR_TAB);
          1: push_put(CHAR_CR);
          2: push_put(CHAR_LF);
          default: push_put(CHAR_W'($urandom));
        endcase
        added++;
      end
    end
  endtask

  task automatic drain();
    do @(negedge clk_i);
    while (console_items_q.size() != 0 || s_axis_tvalid || expected_results_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_phase(input bit do_cfg, input logic [7:0] attr, input logic prompt,
                           input bit s_idle, input bit r_idle, input int unsigned count);
    if (do_cfg) begin
      write_reg(REG_TEXT_ATTR, attr);
      write_reg(REG_PROMPT_EN, {7'b0, prompt});
    end
    send_idle = s_idle;
    recv_idle = r_idle;
    add_random_items(count);
    drain();
  endtask

  initial begin : stimulus
    int i;
    for (i = 0; i < NUM_CELLS; i++) screen_model[i] = {RESET_ATTR, CHAR_BLANK};
    attr_model = RESET_ATTR;
    prompt_model = RESET_PROMPT;
    cur_row = 0;
    cur_col = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // corners of the screen, reads off the screen, odd bytes, tab, CR, LF with prompt
    push_read(5'd0, 7'd0);
    push_read(5'd24, 7'd79);
    push_read(5'd31, 7'd127);
    push_read(5'd25, 7'd0);
    push_read(5'd0, 7'd80);
    push_put(8'h41);
    push_put(8'h00);
    push_put(8'hFF);
    push_put(8'h07);
    push_put(CHAR_TAB);
    push_put(CHAR_CR);
    push_put(CHAR_LF);
    push_read(5'd1, 7'd0);
    push_read(5'd0, 7'd2);
    // tabs up to the wrap at the last column
    repeat (10) push_put(CHAR_TAB);
    push_read(5'd2, 7'd0);

    run_phase(1'b0, RESET_ATTR, RESET_PROMPT, 1'b1, 1'b1, 120);
    run_phase(1'b1, 8'h00, 1'b0, 1'b0, 1'b0, 140);
    run_phase(1'b1, 8'hFF, 1'b1, 1'b1, 1'b0, 140);
    run_phase(1'b1, 8'($urandom), 1'b0, 1'b0, 1'b1, 140);
    run_phase(1'b1, 8'($urandom), 1'b1, 1'b1, 1'b1, 150);

    if (expected_results_q.size() != 0) begin
      $display("%0d expected results never arrived", expected_results_q.size());
      n_errors++;
    end
    $display("covered %0d items: %0d puts, %0d reads (%0d off screen), %0d scrolls",
             n_items, n_puts, n_reads, n_off_screen, n_scrolls);
    $display("%0d register writes, %0d results checked, %0d mismatches",
             n_cfg, n_results, n_errors);
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
